/* rtl/core/deq_pkg.sv */
// package of types, constants and ring helpers for the record deque
package deq_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TAG_W = 16;
    localparam int AGE_W = 8;

    localparam logic [IDX_W:0]   SUM_DEPTH = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_LIST_ODD   = 3'd4,
        MODE_OLDEST     = 3'd5,
        MODE_LIST_ALL   = 3'd6,
        MODE_CLEAR      = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } record_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        record_t          wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic             last;
    } result_t;

    // ring slot at offset off from base, off below DEPTH
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_DEPTH) begin
            sum = sum - SUM_DEPTH;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

endpackage

/* rtl/core/deq_ram.sv */
// record ring memory, one write and one registered read per cycle
module deq_ram
    import deq_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output record_t  rd_data
);

    record_t mem [DEPTH];
    record_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/deq_ctrl.sv */
// deque sequencer: ring pointers, push and pop access, front-to-back scans
module deq_ctrl
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       mode,
    input  logic [TAG_W-1:0] entry_tag,
    input  logic [AGE_W-1:0] entry_age,
    input  logic             out_free,
    output logic             emit,
    output result_t          emit_res,
    output ram_req_t         ram_req,
    input  record_t          rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    mode_t            op_reg, op_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_vld_reg, pend_vld_next;
    record_t          pend_reg, pend_next;
    result_t          res_reg, res_next;

    logic [CNT_W-1:0] cnt_dec;
    logic             empty;
    logic             last_ent;
    logic             advance;
    logic             odd;
    result_t          empty_res;
    record_t          final_rec;

    assign cnt_dec   = count_reg - CNT_W'(1);
    assign empty     = (count_reg == '0);
    assign last_ent  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign odd       = rd_data.age[0];
    assign empty_res = '{status: ST_EMPTY, tag: '0, age: '0, last: 1'b1};
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        emit          = 1'b0;
        emit_res      = res_reg;
        advance       = 1'b0;
        final_rec     = rd_data;
        ram_req.we    = 1'b0;
        ram_req.waddr = front_reg;
        ram_req.wdata = '{tag: entry_tag, age: entry_age};
        ram_req.raddr = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (mode_t'(mode) == MODE_POP_BACK)
                begin
                    ram_req.raddr = slot_add(front_reg, cnt_dec[IDX_W-1:0]);
                end
                if (in_valid)
                begin
                    op_next = mode_t'(mode);
                    unique case (mode_t'(mode))
                        MODE_PUSH_FRONT, MODE_PUSH_BACK:
                        begin
                            state_next = S_EMIT;
                            if (count_reg == FULL_CNT)
                            begin
                                res_next = '{status: ST_FULL, tag: '0, age: '0, last: 1'b1};
                            end
                            else
                            begin
                                ram_req.we = 1'b1;
                                if (mode_t'(mode) == MODE_PUSH_FRONT)
                                begin
                                    ram_req.waddr = idx_dec(front_reg);
                                    front_next    = idx_dec(front_reg);
                                end
                                else
                                begin
                                    ram_req.waddr = slot_add(front_reg, count_reg[IDX_W-1:0]);
                                end
                                count_next = count_reg + CNT_W'(1);
                                res_next   = '{status: ST_OK, tag: '0, age: '0, last: 1'b1};
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_next   = empty_res;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                if (mode_t'(mode) == MODE_POP_FRONT)
                                begin
                                    front_next = idx_inc(front_reg);
                                end
                                count_next = cnt_dec;
                                state_next = S_POP;
                            end
                        end
                        MODE_LIST_ODD, MODE_OLDEST, MODE_LIST_ALL:
                        begin
                            if (empty)
                            begin
                                res_next   = empty_res;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                idx_next      = '0;
                                pend_vld_next = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            state_next = S_EMIT;
                            if (empty)
                            begin
                                res_next = empty_res;
                            end
                            else
                            begin
                                count_next = '0;
                                front_next = '0;
                                res_next   = '{status: ST_OK, tag: '0, age: '0, last: 1'b1};
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_next = '{status: ST_OK, tag: rd_data.tag, age: rd_data.age, last: 1'b1};
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_res   = res_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                ram_req.raddr = slot_add(front_reg, idx_reg);
                unique case (op_reg)
                    MODE_LIST_ALL:
                    begin
                        if (out_free)
                        begin
                            emit     = 1'b1;
                            emit_res = '{status: ST_OK, tag: rd_data.tag, age: rd_data.age,
                                         last: last_ent};
                            if (last_ent)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                    end
                    MODE_LIST_ODD:
                    begin
                        // a held match goes out only once a later match proves it is not last
                        if (!(odd && pend_vld_reg && !out_free))
                        begin
                            if (odd && pend_vld_reg)
                            begin
                                emit     = 1'b1;
                                emit_res = '{status: ST_OK, tag: pend_reg.tag,
                                             age: pend_reg.age, last: 1'b0};
                            end
                            if (odd)
                            begin
                                pend_next     = rd_data;
                                pend_vld_next = 1'b1;
                            end
                            if (last_ent)
                            begin
                                final_rec = odd ? rd_data : pend_reg;
                                if (odd || pend_vld_reg)
                                begin
                                    res_next = '{status: ST_OK, tag: final_rec.tag,
                                                 age: final_rec.age, last: 1'b1};
                                end
                                else
                                begin
                                    res_next = '{status: ST_NOMATCH, tag: '0, age: '0,
                                                 last: 1'b1};
                                end
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                    end
                    MODE_OLDEST:
                    begin
                        // strict compare keeps the front-most of equal maxima
                        final_rec = pend_reg;
                        if ((idx_reg == '0) || (rd_data.age > pend_reg.age))
                        begin
                            final_rec = rd_data;
                        end
                        pend_next = final_rec;
                        if (last_ent)
                        begin
                            res_next   = '{status: ST_OK, tag: final_rec.tag,
                                           age: final_rec.age, last: 1'b1};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
                if (advance)
                begin
                    idx_next      = idx_reg + IDX_W'(1);
                    ram_req.raddr = slot_add(front_reg, idx_reg + IDX_W'(1));
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_res   = res_reg;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= MODE_PUSH_FRONT;
            front_reg    <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            pend_reg     <= pend_next;
            res_reg      <= res_next;
        end
    end

endmodule

/* rtl/core/double_ended_queue_with_scans.sv */
// top level of the bounded record deque with list and oldest-entry scans
//
// a bounded double-ended queue of records (16-bit tag, 8-bit age) held in a
// ring of DEPTH slots in one synchronous memory with a registered read. each
// request carries a mode: push front, push back, pop front, pop back, list
// odd ages, oldest, list all or clear. pushes, pops, clear and every request
// on an empty store give one result. list and oldest requests walk the ring
// from front to back through the single memory read port, one entry a cycle
// while list scans are not stalled; list results stream out as they are
// found, and the final result of every request has last set. a push writes
// the ring in its accept cycle, before the sequencer passes through its
// result state back to idle, so no forwarding path is needed. a one-entry
// output register lets a new request enter while a result is still waiting;
// list scans stall when that register cannot be freed. the memory needs no
// clearing pass after reset: only slots that a push has written are read.
module double_ended_queue_with_scans
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       mode,
    input  logic [TAG_W-1:0] entry_tag,
    input  logic [AGE_W-1:0] entry_age,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [TAG_W-1:0] out_tag,
    output logic [AGE_W-1:0] out_age,
    output logic             last
);

    // output register between the sequencer and the result channel
    logic     out_vld_reg;
    result_t  out_res_reg;
    logic     out_free;

    logic     emit;
    result_t  emit_res;
    ram_req_t ram_req;
    record_t  rd_data;

    // the register can take a result when empty or being drained this cycle
    assign out_free = !out_vld_reg || out_ready;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .entry_tag (entry_tag),
        .entry_age (entry_age),
        .out_free  (out_free),
        .emit      (emit),
        .emit_res  (emit_res),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    // ring storage for tag and age
    deq_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // payload only loads, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_res_reg <= emit_res;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = out_res_reg.status;
    assign out_tag   = out_res_reg.tag;
    assign out_age   = out_res_reg.age;
    assign last      = out_res_reg.last;

endmodule
